// File: sv/assert_macros.svh
// Assertion macros shared by the guidance angle block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/lga_pkg.sv
// Package: constants, CORDIC angle table and controller/datapath command types
`default_nettype none
package lga_pkg;
	localparam int CordicSteps = 24;
	localparam int StepW = 5;
	localparam logic [27:0] HalfPiQ24 = 28'd26353589;
	localparam logic [27:0] PiQ24 = 28'd52707179;
	localparam logic [14:0] PiQ13 = 15'd25736;

	function automatic logic [23:0] atan_q24(input logic [StepW-1:0] i);
		logic [23:0] r;
		unique case (i)
			5'd0: r = 24'd13176795;
			5'd1: r = 24'd7778716;
			5'd2: r = 24'd4110060;
			5'd3: r = 24'd2086331;
			5'd4: r = 24'd1047214;
			5'd5: r = 24'd524117;
			5'd6: r = 24'd262123;
			5'd7: r = 24'd131069;
			default: r = 24'd65536 >> (i - 5'd8);
		endcase
		return r;
	endfunction

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic plane_start;
		logic plane_sel;
		logic shrink;
		logic mul;
		logic sum;
		logic prep;
		logic norm;
		logic step;
		logic [StepW-1:0] idx;
		logic finish;
	} lga_cmd_t;

	typedef struct packed {
		logic shrink_done;
		logic norm_done;
	} lga_sts_t;
endpackage
`default_nettype wire

// File: sv/lga_datapath.sv
// Datapath: aim point store, vector reduction, products, CORDIC and rounding
`default_nettype none
module lga_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire lga_pkg::lga_cmd_t cmd,
	output lga_pkg::lga_sts_t sts,
	input wire logic signed [31:0] pos_x, pos_y, pos_z,
	input wire logic signed [31:0] vel_x, vel_y, vel_z,
	input wire logic signed [31:0] look_x, look_y, look_z,
	input wire logic look_valid,
	output logic signed [15:0] pitch_angle,
	output logic [14:0] yaw_angle,
	output logic signed [31:0] aim_x, aim_y, aim_z
);
	import lga_pkg::*;

	logic signed [31:0] last_q [3];
	logic signed [32:0] ax_q, ay_q, az_q;
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic signed [32:0] a1_q, a2_q, v1_q, v2_q;
	logic zero_q;
	logic signed [63:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [64:0] dot_q, cross_q;
	logic signed [64:0] cx_q, cy_q;
	logic signed [28:0] z_q;
	logic [14:0] pitch_q, yaw_q;

	// aim point store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q[0] <= '0;
			last_q[1] <= '0;
			last_q[2] <= '0;
		end else if (cmd.load && look_valid) begin
			last_q[0] <= look_x;
			last_q[1] <= look_y;
			last_q[2] <= look_z;
		end
	end
	assign aim_x = last_q[0];
	assign aim_y = last_q[1];
	assign aim_z = last_q[2];

	// reduction: one right shift per cycle until both magnitudes fit
	logic big_a, big_v;
	function automatic logic fits(input logic signed [32:0] p, input logic signed [32:0] q);
		logic [32:0] mp, mq;
		mp = p[32] ? -p : p;
		mq = q[32] ? -q : q;
		return ((mp | mq) >> 30) == '0;
	endfunction
	function automatic logic signed [32:0] half(input logic signed [32:0] p);
		logic [32:0] m;
		m = p[32] ? -p : p;
		m = m >> 1;
		return p[32] ? -$signed(m) : $signed(m);
	endfunction
	assign big_a = !fits(a1_q, a2_q);
	assign big_v = !fits(v1_q, v2_q);
	assign sts.shrink_done = !big_a && !big_v;

	// normalize detect; a zero-length plane skips normalizing
	logic [64:0] nor_or;
	assign nor_or = cx_q | cy_q;
	assign sts.norm_done = (nor_or[64:59] != '0) || zero_q;

	logic signed [64:0] cxs, cys;
	assign cxs = cx_q >>> cmd.idx;
	assign cys = cy_q >>> cmd.idx;

	logic [28:0] zr;
	logic [28:0] zc;
	logic [17:0] rr;
	always_comb begin
		zc = z_q[28] ? 29'd0 : ((z_q > $signed({1'b0, PiQ24})) ? {1'b0, PiQ24} : z_q);
		zr = zc + 29'd1024;
		rr = zr[28:11];
		if (rr > 18'(PiQ13)) rr = 18'(PiQ13);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= (look_valid ? 33'(look_x) : 33'(last_q[0])) - 33'(pos_x);
			ay_q <= (look_valid ? 33'(look_y) : 33'(last_q[1])) - 33'(pos_y);
			az_q <= (look_valid ? 33'(look_z) : 33'(last_q[2])) - 33'(pos_z);
			vx_q <= vel_x;
			vy_q <= vel_y;
			vz_q <= vel_z;
		end
		if (cmd.plane_start) begin
			// plane 0: pitch (y,z); plane 1: yaw (x,y)
			a1_q <= cmd.plane_sel ? ax_q : ay_q;
			a2_q <= cmd.plane_sel ? ay_q : az_q;
			v1_q <= 33'(cmd.plane_sel ? vx_q : vy_q);
			v2_q <= 33'(cmd.plane_sel ? vy_q : vz_q);
			zero_q <= cmd.plane_sel
				? ((ax_q == 0 && ay_q == 0) || (vx_q == 0 && vy_q == 0))
				: ((ay_q == 0 && az_q == 0) || (vy_q == 0 && vz_q == 0));
		end
		if (cmd.shrink) begin
			if (big_a) begin
				a1_q <= half(a1_q);
				a2_q <= half(a2_q);
			end
			if (big_v) begin
				v1_q <= half(v1_q);
				v2_q <= half(v2_q);
			end
		end
		// one signed multiplier per product, registered
		if (cmd.mul) begin
			p1_q <= 64'($signed(a1_q[31:0]) * $signed(v1_q[31:0]));
			p2_q <= 64'($signed(a2_q[31:0]) * $signed(v2_q[31:0]));
			p3_q <= 64'($signed(a1_q[31:0]) * $signed(v2_q[31:0]));
			p4_q <= 64'($signed(a2_q[31:0]) * $signed(v1_q[31:0]));
		end
		if (cmd.sum) begin
			dot_q <= 65'(p1_q) + 65'(p2_q);
			cross_q <= 65'(p3_q) - 65'(p4_q);
		end
		// quadrant fold: dot < 0 turns by -pi/2
		if (cmd.prep) begin
			if (dot_q[64]) begin
				cx_q <= cross_q[64] ? -cross_q : cross_q;
				cy_q <= -dot_q;
				z_q <= 29'(HalfPiQ24);
			end else begin
				cx_q <= dot_q;
				cy_q <= cross_q[64] ? -cross_q : cross_q;
				z_q <= '0;
			end
		end
		if (cmd.norm) begin
			cx_q <= cx_q <<< 1;
			cy_q <= cy_q <<< 1;
		end
		// one CORDIC vectoring step per cycle
		if (cmd.step) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + cys;
				cy_q <= cy_q - cxs;
				z_q <= z_q + $signed({5'd0, atan_q24(cmd.idx)});
			end else begin
				cx_q <= cx_q - cys;
				cy_q <= cy_q + cxs;
				z_q <= z_q - $signed({5'd0, atan_q24(cmd.idx)});
			end
		end
		if (cmd.finish) begin
			if (cmd.plane_sel) yaw_q <= zero_q ? 15'd0 : rr[14:0];
			else pitch_q <= zero_q ? 15'd0 : rr[14:0];
		end
	end

	assign pitch_angle = -$signed({1'b0, pitch_q});
	assign yaw_angle = yaw_q;
endmodule
`default_nettype wire

// File: sv/lga_ctrl.sv
// Controller: sequences reduction, products, CORDIC and result handshake
`default_nettype none
`include "assert_macros.svh"
module lga_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	output lga_pkg::lga_cmd_t cmd,
	input wire lga_pkg::lga_sts_t sts
);
	import lga_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_START = 4'd1, S_SHRINK = 4'd2, S_MUL = 4'd3,
		S_SUM = 4'd4, S_PREP = 4'd5, S_NORM = 4'd6, S_STEP = 4'd7, S_FIN = 4'd8,
		S_OUT = 4'd9;

	logic [3:0] state_q;
	logic plane_q;
	logic [StepW-1:0] idx_q;

	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd = '0;
		cmd.plane_sel = plane_q;
		cmd.idx = idx_q;
		cmd.load = state_q == S_IDLE && in_valid;
		cmd.plane_start = state_q == S_START;
		cmd.shrink = state_q == S_SHRINK;
		cmd.mul = state_q == S_MUL;
		cmd.sum = state_q == S_SUM;
		cmd.prep = state_q == S_PREP;
		cmd.norm = state_q == S_NORM && !sts.norm_done;
		cmd.step = state_q == S_STEP;
		cmd.finish = state_q == S_FIN;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plane_q <= 1'b0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_START;
					plane_q <= 1'b0;
				end
				S_START: state_q <= S_SHRINK;
				S_SHRINK: if (sts.shrink_done) state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_PREP;
				S_PREP: state_q <= S_NORM;
				S_NORM: if (sts.norm_done) begin
					state_q <= S_STEP;
					idx_q <= '0;
				end
				S_STEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == StepW'(CordicSteps - 1)) state_q <= S_FIN;
				end
				S_FIN: begin
					if (plane_q) state_q <= S_OUT;
					else begin
						plane_q <= 1'b1;
						state_q <= S_START;
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLY(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_IMPLY(a_idx_range, clk, arst_n, state_q == S_STEP, idx_q < StepW'(CordicSteps))
endmodule
`default_nettype wire

// File: sv/lookahead_guidance_angles.sv
// Top level: pure-pursuit lookahead pitch and yaw angles
// Per plane: after a setup step, the vectors are reduced by one bit a cycle (0 to 2 shifts
// until both fit), then come the products, the sums and the quadrant fold; the CORDIC
// input is normalized one bit a cycle (0 to 59 shifts; short vectors take longest, a
// zero-length plane skips it), then 24 vectoring steps and a rounding step run on one
// shared CORDIC unit; the two planes go through it in turn. One request is processed at
// a time; the result is held until taken, and the next request is accepted only then.
`default_nettype none
module lookahead_guidance_angles (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] pos_x, pos_y, pos_z,
	input wire logic signed [31:0] vel_x, vel_y, vel_z,
	input wire logic signed [31:0] look_x, look_y, look_z,
	input wire logic look_valid,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [15:0] pitch_angle,
	output logic [14:0] yaw_angle,
	output logic signed [31:0] aim_x, aim_y, aim_z
);
	import lga_pkg::*;
	lga_cmd_t cmd;
	lga_sts_t sts;

	lga_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts);
	lga_datapath u_dp (.clk, .arst_n, .cmd, .sts, .pos_x, .pos_y, .pos_z, .vel_x, .vel_y,
		.vel_z, .look_x, .look_y, .look_z, .look_valid, .pitch_angle, .yaw_angle,
		.aim_x, .aim_y, .aim_z);
endmodule
`default_nettype wire

// File: sim/tb_lookahead_guidance_angles.sv
// Testbench for the pure-pursuit lookahead pitch and yaw angle block
`default_nettype none
module tb_lookahead_guidance_angles;
	import lga_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int NumRandom = 1250;

	typedef struct packed {
		logic signed [31:0] px, py, pz, vx, vy, vz, lx, ly, lz;
		logic lv;
	} guid_req_t;

	typedef struct packed {
		logic signed [15:0] pitch;
		logic [14:0] yaw;
		logic signed [31:0] ax, ay, az;
	} guid_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic signed [31:0] look_x = '0, look_y = '0, look_z = '0;
	logic look_valid = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] pitch_angle;
	logic [14:0] yaw_angle;
	logic signed [31:0] aim_x, aim_y, aim_z;

	guid_res_t angles_due[$];
	logic [31:0] held_point [3];
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit timed_out = 1'b0;

	lookahead_guidance_angles dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.look_x(look_x), .look_y(look_y), .look_z(look_z),
		.look_valid(look_valid),
		.out_valid(out_valid), .out_stall(out_stall),
		.pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// floor shift of a signed value
	function automatic longint asr(input longint v, input int s);
		return v >>> s;
	endfunction

	// bring magnitudes under 2^30 by a common truncating shift
	function automatic void reduce_pair(ref longint p, ref longint q);
		longint unsigned mp, mq;
		int s;
		mp = p < 0 ? -p : p;
		mq = q < 0 ? -q : q;
		s = 0;
		while (((mp | mq) >> s) >= (64'd1 << 30))
			s++;
		mp >>= s;
		mq >>= s;
		p = (p < 0) ? -longint'(mp) : longint'(mp);
		q = (q < 0) ? -longint'(mq) : longint'(mq);
	endfunction

	// angle between aim and velocity in one plane, unsigned Q2.13
	function automatic logic [14:0] plane_angle(input longint a1, a2, v1, v2);
		longint dot, crs, cx, cy, z, t;
		longint unsigned ux, uy, r;
		if ((a1 == 0 && a2 == 0) || (v1 == 0 && v2 == 0))
			return '0;
		reduce_pair(a1, a2);
		reduce_pair(v1, v2);
		dot = a1 * v1 + a2 * v2;
		crs = a1 * v2 - a2 * v1;
		z = 0;
		uy = crs < 0 ? -crs : crs;
		// obtuse: rotate by -pi/2 first
		if (dot < 0) begin
			ux = uy;
			uy = -dot;
			z = HalfPiQ24;
		end else begin
			ux = dot;
		end
		while (((ux | uy) >> 59) == 0) begin
			ux <<= 1;
			uy <<= 1;
		end
		cx = ux;
		cy = uy;
		for (int i = 0; i < CordicSteps; i++) begin
			t = cx;
			if (cy > 0) begin
				cx = cx + asr(cy, i);
				cy = cy - asr(t, i);
				z += atan_q24(i[StepW-1:0]);
			end else begin
				cx = cx - asr(cy, i);
				cy = cy + asr(t, i);
				z -= atan_q24(i[StepW-1:0]);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(PiQ24)) z = PiQ24;
		r = (z + 1024) >> 11;
		if (r > PiQ13) r = PiQ13;
		return r[14:0];
	endfunction

	// predicted result for one request; updates the held aim point
	function automatic guid_res_t predict_angles(input guid_req_t q);
		guid_res_t e;
		longint ax, ay, az;
		if (q.lv) begin
			held_point[0] = q.lx;
			held_point[1] = q.ly;
			held_point[2] = q.lz;
		end
		ax = longint'($signed(held_point[0])) - longint'(q.px);
		ay = longint'($signed(held_point[1])) - longint'(q.py);
		az = longint'($signed(held_point[2])) - longint'(q.pz);
		e.pitch = -$signed({1'b0, plane_angle(ay, az, q.vy, q.vz)});
		e.yaw = plane_angle(ax, ay, q.vx, q.vy);
		e.ax = held_point[0];
		e.ay = held_point[1];
		e.az = held_point[2];
		return e;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one request, predicting its result on acceptance
	task automatic send_request(input guid_req_t q, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) @(negedge clk);
		{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, look_x, look_y, look_z, look_valid} = q;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		angles_due.push_back(predict_angles(q));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_coord();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(0, 2000 << 16)) - (1000 << 16);
		endcase
	endfunction

	function automatic guid_req_t rand_request();
		guid_req_t q;
		q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0};
		q.lv = $urandom_range(0, 3) != 0;
		return q;
	endfunction

	// extremes, zero vectors, missing lookahead point, obtuse and parallel cases
	task automatic test_directed();
		guid_req_t q;
		q = '0;
		send_request(q, 0);
		q = '{px: 0, py: 0, pz: 0, vx: 32'h10000, vy: 0, vz: 0, lx: 32'h10000,
			ly: 32'h10000, lz: 32'h10000, lv: 1};
		send_request(q, 0);
		q.lv = 0; q.lx = 32'h7FFF_FFFF;
		send_request(q, 0);
		q.vx = -32'sh10000; q.vy = -32'sh10000; q.vz = -32'sh10000;
		send_request(q, 0);
		q = '{px: 32'h8000_0000, py: 32'h8000_0000, pz: 32'h8000_0000,
			vx: 32'h7FFF_FFFF, vy: 32'h7FFF_FFFF, vz: 32'h7FFF_FFFF,
			lx: 32'h7FFF_FFFF, ly: 32'h7FFF_FFFF, lz: 32'h7FFF_FFFF, lv: 1};
		send_request(q, 0);
		q.vx = 32'h8000_0000; q.vy = 32'h8000_0000; q.vz = 32'h8000_0000;
		send_request(q, 0);
		q = '{px: 32'h7FFF_FFFF, py: 32'h7FFF_FFFF, pz: 32'h7FFF_FFFF,
			vx: 32'hFFFF_FFFF, vy: 32'h1, vz: 32'h0,
			lx: 32'h8000_0000, ly: 32'h8000_0000, lz: 32'h8000_0000, lv: 1};
		send_request(q, 0);
		// aim equals position: zero aim length
		q = '{px: 32'h30000, py: 32'h50000, pz: 32'h1, vx: 32'h1, vy: 32'h1, vz: 32'h1,
			lx: 32'h30000, ly: 32'h50000, lz: 32'h1, lv: 1};
		send_request(q, 0);
		q.lv = 0; q.px = 0; q.vy = 32'hFFFF_0000; q.vz = 32'h5555_AAAA;
		send_request(q, 0);
		q.px = 32'hAAAA_5555; q.pz = 32'h5555_AAAA; q.vx = 32'h0F0F_F0F0;
		send_request(q, 0);
	endtask

	task automatic test_random();
		for (int n = 0; n < NumRandom; n++)
			send_request(rand_request(), 1);
	endtask

	// receiver holds off long so the block fills and stalls its input
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 20; n++)
				send_request(rand_request(), 0);
		join
	endtask

	// receiver stall pattern
	initial begin
		int g;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				g = gap_len();
				if (g == 0) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		guid_res_t got, want;
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pitch: pitch_angle, yaw: yaw_angle, ax: aim_x, ay: aim_y, az: aim_z};
			if (angles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = angles_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	initial begin
		wait (idle_cycles >= WatchdogLimit);
		timed_out = 1'b1;
		$display("FAIL lookahead_guidance_angles");
		$finish;
	end

	initial begin
		held_point = '{default: '0};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random();
		wait (angles_due.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && !timed_out)
			$display("PASS lookahead_guidance_angles");
		else
			$display("FAIL lookahead_guidance_angles");
		$finish;
	end
endmodule
`default_nettype wire
